// File: rtl/assert_macros.svh
// Assertion macros used by the queue's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TRPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("trpq assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define TRPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trpq implication failed");

// Check that a condition implies a consequence in the next cycle.
`define TRPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trpq sequence failed");

`endif

// File: rtl/trpq_pkg.sv
// Package: sizes, codes and controller/datapath interface types of the queue.
`default_nettype none

package trpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned LEN_W       = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_RELEASED = 2'd2,
    KIND_DROPPED  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] release_t;
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  length;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the input transfer
    logic scan_start;  // clear scan and compaction pointers
    logic ins_commit;  // append (or reject) and load the result
    logic rd_issue;    // read the entry under the scan pointer
    logic ev_keep;     // move the evaluated entry down to the keep pointer
    logic ev_remove;   // emit any pending result, park the evaluated entry
    logic flush;       // emit the pending result as final
    logic finish;      // commit the new count, clear the pending slot
  } trpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             count_zero;
    logic [CNT_W-1:0] count;
    logic             scan_last;
    logic             hit_remove;
    logic             pend_valid;
    logic             out_free;
  } trpq_sts_t;

endpackage

`default_nettype wire

// File: rtl/trpq_dp.sv
// Datapath: descriptor memory, scan/compaction pointers, pending and output registers.
`default_nettype none

module trpq_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire trpq_pkg::trpq_cmd_t             cmd_i,
  output trpq_pkg::trpq_sts_t                  sts_o,
  input  wire logic [trpq_pkg::TIME_W-1:0]     release_time_i,
  input  wire logic [trpq_pkg::TIME_W-1:0]     drop_time_i,
  input  wire logic [trpq_pkg::TAG_W-1:0]      tag_i,
  input  wire logic [trpq_pkg::LEN_W-1:0]      length_i,
  input  wire logic [trpq_pkg::TIME_W-1:0]     now_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [1:0]                           kind_o,
  output logic [trpq_pkg::TAG_W-1:0]           tag_res_o,
  output logic [trpq_pkg::LEN_W-1:0]           length_res_o,
  output logic                                 last_o
);

  trpq_pkg::entry_t mem_q [trpq_pkg::QUEUE_DEPTH];
  trpq_pkg::entry_t rd_data_q;
  trpq_pkg::entry_t in_q;
  logic [trpq_pkg::TIME_W-1:0] now_q;

  logic [trpq_pkg::CNT_W-1:0] count_q, count_d;
  logic [trpq_pkg::IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [trpq_pkg::CNT_W-1:0] wr_idx_q, wr_idx_d;

  logic                        pend_valid_q, pend_valid_d;
  trpq_pkg::kind_e             pend_kind_q;
  logic [trpq_pkg::TAG_W-1:0]  pend_tag_q;
  logic [trpq_pkg::LEN_W-1:0]  pend_len_q;

  logic                        out_valid_q, out_valid_d;
  trpq_pkg::kind_e             out_kind_q;
  logic [trpq_pkg::TAG_W-1:0]  out_tag_q;
  logic [trpq_pkg::LEN_W-1:0]  out_len_q;
  logic                        out_last_q;

  logic                        full;
  logic                        hit_drop;
  logic                        hit_release;
  logic                        wr_en;
  logic [trpq_pkg::IDX_W-1:0]  wr_addr;
  trpq_pkg::entry_t            wr_data;
  logic                        out_load;

  assign full        = (count_q == trpq_pkg::CNT_W'(trpq_pkg::QUEUE_DEPTH));
  assign hit_drop    = (rd_data_q.deadline != '0) && (rd_data_q.deadline < now_q);
  assign hit_release = (rd_data_q.release_t < now_q);

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count      = count_q;
  assign sts_o.scan_last  =
    ((trpq_pkg::CNT_W'(rd_idx_q) + trpq_pkg::CNT_W'(1)) == count_q);
  assign sts_o.hit_remove = hit_drop || hit_release;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // One write port: append on insert, compaction move during a scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx_q[trpq_pkg::IDX_W-1:0];
    wr_data = rd_data_q;
    if (cmd_i.ins_commit && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[trpq_pkg::IDX_W-1:0];
      wr_data = in_q;
    end else if (cmd_i.ev_keep) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  always_comb begin
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    pend_valid_d = pend_valid_q;
    if (cmd_i.ins_commit && !full) begin
      count_d = count_q + trpq_pkg::CNT_W'(1);
    end
    if (cmd_i.scan_start) begin
      rd_idx_d = '0;
      wr_idx_d = '0;
    end
    if (cmd_i.ev_keep || cmd_i.ev_remove) begin
      rd_idx_d = rd_idx_q + trpq_pkg::IDX_W'(1);
    end
    if (cmd_i.ev_keep) begin
      wr_idx_d = wr_idx_q + trpq_pkg::CNT_W'(1);
    end
    if (cmd_i.ev_remove) begin
      pend_valid_d = 1'b1;
    end
    if (cmd_i.finish) begin
      count_d      = wr_idx_q;
      pend_valid_d = 1'b0;
    end
  end

  assign out_load = cmd_i.ins_commit || (cmd_i.ev_remove && pend_valid_q) || cmd_i.flush;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      wr_idx_q     <= wr_idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q.release_t <= release_time_i;
      in_q.deadline  <= drop_time_i;
      in_q.tag       <= tag_i;
      in_q.length    <= length_i;
      now_q          <= now_time_i;
    end
    if (cmd_i.ev_remove) begin
      pend_kind_q <= hit_drop ? trpq_pkg::KIND_DROPPED : trpq_pkg::KIND_RELEASED;
      pend_tag_q  <= rd_data_q.tag;
      pend_len_q  <= rd_data_q.length;
    end
    if (cmd_i.ins_commit) begin
      out_kind_q <= full ? trpq_pkg::KIND_REJECTED : trpq_pkg::KIND_ACCEPTED;
      out_tag_q  <= in_q.tag;
      out_len_q  <= in_q.length;
      out_last_q <= 1'b1;
    end else if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_tag_q  <= pend_tag_q;
      out_len_q  <= pend_len_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign tag_res_o    = out_tag_q;
  assign length_res_o = out_len_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// File: rtl/trpq_ctrl.sv
// Controller: state machine sequencing inserts and tick scans.
`default_nettype none

module trpq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 cmd_i,
  input  wire trpq_pkg::trpq_sts_t  sts_i,
  output trpq_pkg::trpq_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (cmd_i == trpq_pkg::CMD_INSERT) begin
            state_d = ST_INSERT;
          end else if (!sts_i.count_zero) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN_RD;
          end
        end
      end
      ST_INSERT: begin
        if (sts_i.out_free) begin
          cmd_o.ins_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (!sts_i.hit_remove) begin
          cmd_o.ev_keep = 1'b1;
          state_d       = sts_i.scan_last ? ST_FLUSH : ST_SCAN_RD;
        end else if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.ev_remove = 1'b1;
          state_d         = sts_i.scan_last ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush  = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/timed_release_packet_queue.sv
// An insert's result is registered when the insert state commits, later if the result stalls.
// One item at a time: an insert captures and then commits; a tick on an empty queue only captures;
//   otherwise a tick scans its N queued entries, one read and one evaluate step each, then flushes.
// A result stall holds an insert, and holds a scan when a removal or the final flush finds
//   a parked result and a busy output register.
// Reset (rst_ni low, asynchronous) empties the queue; descriptor storage is left as is.
`default_nettype none

`include "assert_macros.svh"

module timed_release_packet_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Command channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [trpq_pkg::TIME_W-1:0]   release_time_i,
  input  wire logic [trpq_pkg::TIME_W-1:0]   drop_time_i,
  input  wire logic [trpq_pkg::TAG_W-1:0]    tag_i,
  input  wire logic [trpq_pkg::LEN_W-1:0]    length_i,
  input  wire logic [trpq_pkg::TIME_W-1:0]   now_time_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [trpq_pkg::TAG_W-1:0]         tag_res_o,
  output logic [trpq_pkg::LEN_W-1:0]         length_res_o,
  output logic                               last_o
);

  // Controller and datapath talk only through these two bundles.
  trpq_pkg::trpq_cmd_t dp_cmd;
  trpq_pkg::trpq_sts_t dp_sts;

  // Sequence inserts and scans; the controller owns the input stall.
  trpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Hold descriptors, compact survivors in place, and register each result.
  // A removed entry is parked until the next removal or the flush so that the final one can carry last.
  trpq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .release_time_i (release_time_i),
    .drop_time_i    (drop_time_i),
    .tag_i          (tag_i),
    .length_i       (length_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .tag_res_o      (tag_res_o),
    .length_res_o   (length_res_o),
    .last_o         (last_o)
  );

  // The fill count never passes the queue depth.
  `TRPQ_ASSERT(a_count_bound, dp_sts.count <= trpq_pkg::CNT_W'(trpq_pkg::QUEUE_DEPTH))
  // An insert or flush result is loaded only into a free output register.
  `TRPQ_ASSERT_IMP(a_ins_free, dp_cmd.ins_commit || dp_cmd.flush, dp_sts.out_free)
  // An accepted insert blocks the next transfer.
  `TRPQ_ASSERT_NEXT(a_ins_busy, in_valid_i && !in_stall_o && (cmd_i == trpq_pkg::CMD_INSERT),
                    in_stall_o)
  // No removal stays parked once the block is idle again.
  `TRPQ_ASSERT_IMP(a_idle_no_pend, !in_stall_o, !dp_sts.pend_valid)

endmodule

`default_nettype wire
